### hdl/swr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swr_pkg
// shared types and constants of the sliding window reorder receiver
// ----------------------------------------------------------------------------
package swr_pkg;

  // fixed field widths
  localparam int SEQ_W      = 16;
  localparam int CNT_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  // depth of the queue between front and back
  localparam int QUEUE_D = 2;
  localparam int QUEUE_A = 1;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_SEQ_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_BITS = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_EXP    = 2'd2;

  // reset values of the configuration registers
  localparam logic [4:0]       RST_SEQ_BITS    = 5'd8;
  localparam logic [2:0]       RST_WINDOW_BITS = 3'd2;
  localparam logic [SEQ_W-1:0] RST_INIT_EXP    = '0;

  localparam logic [CNT_W-1:0] DROP_MAX = '1;

  // classified beat handed from front to back
  typedef struct packed {
    logic [SEQ_W-1:0] seq;
    logic             invalid;
  } swr_item_t;

  // one result beat
  typedef struct packed {
    logic             delivered_valid;
    logic [SEQ_W-1:0] delivered_seq;
    logic             last_result;
    logic             dropped;
    logic             invalid_packet;
    logic [CNT_W-1:0] drop_total;
    logic [SEQ_W-1:0] next_expected;
  } swr_result_t;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } swr_state_t;

endpackage : swr_pkg
`default_nettype wire

### hdl/sliding_window_reorder_receiver.sv
`default_nettype none
// ----------------------------------------------------------------------------
// sliding_window_reorder_receiver
// selective repeat receive side: holds out-of-order packets, delivers in order
// ----------------------------------------------------------------------------
// usage
//   in_*  : one packet sequence number per beat (valid/ready)
//   out_* : result beats (valid/ready); each input beat yields one status beat
//           or one beat per in-order delivery, the final one has last_result
//   cfg_* : register write port; a write to a known index is registered and,
//           through a registered reload, restarts the window (expected number
//           reloaded, bitmap cleared); the drop counter is kept
// path
//   input register, then a two-entry queue, then a classify step in the
//   back end, then the result register; a beat beyond the sequence space
//   skips the classify step
// throughput
//   the back end takes one item at a time: it classifies the item, then
//   emits its result beats, and takes no new item until the last one; the
//   bitmap drain of one delivery per cycle while out_ready is high sets
//   the pace
// reset
//   registers return to 8 sequence bits, window of 4, expected number 0;
//   bitmap and drop counter clear
// stalls
//   out_ready low stalls result beats, though one more item may be classified;
//   the queue and input register keep taking beats until they fill
// ----------------------------------------------------------------------------
module sliding_window_reorder_receiver import swr_pkg::*; #(
  parameter int MAX_SEQ_BITS = 16,
  parameter int MAX_WINDOW   = 64
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  // configuration
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // input beats
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [SEQ_W-1:0]      in_sequence_number,
  // result beats
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic                       out_delivered_valid,
  output logic [SEQ_W-1:0]           out_delivered_seq,
  output logic                       out_last_result,
  output logic                       out_dropped,
  output logic                       out_invalid_packet,
  output logic [CNT_W-1:0]           out_drop_total,
  output logic [SEQ_W-1:0]           out_next_expected
);

  // internal sequence width covers both the field and the largest modulus
  localparam int SW_W   = (MAX_SEQ_BITS > SEQ_W) ? MAX_SEQ_BITS : SEQ_W;
  // largest window exponent whose window fits the bitmap
  localparam int WB_MAX = $clog2(MAX_WINDOW + 1) - 1;
  localparam logic [5:0] SB_MAX = 6'(MAX_SEQ_BITS);
  localparam logic [5:0] WB_TOP = 6'(WB_MAX);

  // configuration registers
  logic [4:0]       seq_bits_r;
  logic [2:0]       window_bits_r;
  logic [SEQ_W-1:0] init_exp_r;
  logic             reload_r, reload_nxt;

  logic [5:0]      eff_sb, eff_wb;
  logic [SW_W-1:0] seq_mask, win_lo, init_exp;

  always_comb begin
    reload_nxt = 1'b0;
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_SEQ_BITS, CFG_WINDOW_BITS, CFG_INIT_EXP: reload_nxt = 1'b1;
        default:                                     reload_nxt = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_bits_r    <= RST_SEQ_BITS;
      window_bits_r <= RST_WINDOW_BITS;
      init_exp_r    <= RST_INIT_EXP;
      reload_r      <= 1'b0;
    end else begin
      reload_r <= reload_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SEQ_BITS:    seq_bits_r    <= cfg_data[4:0];
          CFG_WINDOW_BITS: window_bits_r <= cfg_data[2:0];
          CFG_INIT_EXP:    init_exp_r    <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  // effective sequence width and window exponent
  always_comb begin
    eff_sb = {1'b0, seq_bits_r};
    if (eff_sb == 6'd0) begin
      eff_sb = 6'd1;
    end
    if (eff_sb > SB_MAX) begin
      eff_sb = SB_MAX;
    end
    eff_wb = {3'b000, window_bits_r};
    if (eff_wb > eff_sb) begin
      eff_wb = eff_sb;
    end
    if (eff_wb > WB_TOP) begin
      eff_wb = WB_TOP;
    end
    for (int i = 0; i < SW_W; i++) begin
      seq_mask[i] = (6'(i) < eff_sb);
      win_lo[i]   = (6'(i) < eff_wb);
    end
  end

  assign init_exp = SW_W'(init_exp_r) & seq_mask;

  // front to queue to back
  logic        push_valid, push_ready, q_valid, q_pop;
  swr_item_t   push_item, q_item;
  swr_result_t res;

  swr_front #(
    .SW_W (SW_W)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .seq_mask   (seq_mask),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_seq     (in_sequence_number),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  swr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item),
    .pop_valid  (q_valid),
    .pop        (q_pop),
    .pop_item   (q_item)
  );

  swr_back #(
    .SW_W   (SW_W),
    .WB_MAX (WB_MAX)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .reload    (reload_r),
    .init_exp  (init_exp),
    .seq_mask  (seq_mask),
    .win_lo    (win_lo),
    .q_valid   (q_valid),
    .q_item    (q_item),
    .q_pop     (q_pop),
    .out_ready (out_ready),
    .out_valid (out_valid),
    .out_res   (res)
  );

  assign out_delivered_valid = res.delivered_valid;
  assign out_delivered_seq   = res.delivered_seq;
  assign out_last_result     = res.last_result;
  assign out_dropped         = res.dropped;
  assign out_invalid_packet  = res.invalid_packet;
  assign out_drop_total      = res.drop_total;
  assign out_next_expected   = res.next_expected;

endmodule : sliding_window_reorder_receiver
`default_nettype wire

### hdl/swr_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swr_front
// input stage: takes a beat, flags numbers beyond the sequence space
// ----------------------------------------------------------------------------
module swr_front import swr_pkg::*; #(
  parameter int SW_W = 16
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic [SW_W-1:0] seq_mask,
  input  wire logic            in_valid,
  output logic                 in_ready,
  input  wire logic [SEQ_W-1:0] in_seq,
  output logic                 push_valid,
  input  wire logic            push_ready,
  output swr_item_t            push_item
);

  logic      valid_r, valid_nxt;
  swr_item_t item_r, item_nxt;
  logic [SW_W-1:0] seq_ext;

  assign seq_ext = SW_W'(in_seq);

  always_comb begin
    in_ready  = !valid_r || push_ready;
    valid_nxt = valid_r && !push_ready;
    item_nxt  = item_r;
    if (in_valid && in_ready) begin
      valid_nxt        = 1'b1;
      item_nxt.seq     = in_seq;
      // any bit above the modulus makes the number invalid
      item_nxt.invalid = |(seq_ext & ~seq_mask);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r <= item_nxt;
  end

  assign push_valid = valid_r;
  assign push_item  = item_r;

endmodule : swr_front
`default_nettype wire

### hdl/swr_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swr_queue
// short fifo between the front and the back
// ----------------------------------------------------------------------------
module swr_queue import swr_pkg::*; (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic push_valid,
  output logic      push_ready,
  input  swr_item_t push_item,
  output logic      pop_valid,
  input  wire logic pop,
  output swr_item_t pop_item
);

  swr_item_t mem [QUEUE_D];
  logic [QUEUE_A-1:0] wr_ptr_r, rd_ptr_r;
  logic [QUEUE_A:0]   count_r;
  logic do_push, do_pop;

  assign push_ready = (count_r != (QUEUE_A+1)'(QUEUE_D));
  assign pop_valid  = (count_r != '0);
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop && pop_valid;
  assign pop_item   = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      case ({do_push, do_pop})
        2'b10:   count_r <= count_r + 1'b1;
        2'b01:   count_r <= count_r - 1'b1;
        default: count_r <= count_r;
      endcase
    end
  end

endmodule : swr_queue
`default_nettype wire

### hdl/swr_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// swr_back
// window check, held bitmap, drop counter and in-order drain
// ----------------------------------------------------------------------------
module swr_back import swr_pkg::*; #(
  parameter int SW_W   = 16,
  parameter int WB_MAX = 6
) (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            reload,
  input  wire logic [SW_W-1:0] init_exp,
  input  wire logic [SW_W-1:0] seq_mask,
  input  wire logic [SW_W-1:0] win_lo,
  input  wire logic            q_valid,
  input  swr_item_t            q_item,
  output logic                 q_pop,
  input  wire logic            out_ready,
  output logic                 out_valid,
  output swr_result_t          out_res
);

  localparam int MAP_D = 1 << WB_MAX;

  swr_state_t        state_r, state_nxt;
  logic [SW_W-1:0]   exp_r, exp_nxt;
  logic [MAP_D-1:0]  map_r, map_nxt;
  logic [CNT_W-1:0]  drop_r, drop_nxt;
  logic              dr_r, dr_nxt;
  logic [WB_MAX:0]   n_r, n_nxt;
  logic              out_valid_r, out_valid_nxt;
  swr_result_t       res_r, res_nxt;

  logic [WB_MAX-1:0] wmask, cur_idx, nxt_idx, in_idx;
  logic [SW_W-1:0]   exp_inc, seq_ext, gap;
  logic              can_emit, in_win, hit, more;

  assign wmask    = win_lo[WB_MAX-1:0];
  assign can_emit = !out_valid_r || out_ready;
  assign cur_idx  = exp_r[WB_MAX-1:0] & wmask;
  assign exp_inc  = (exp_r + 1'b1) & seq_mask;
  assign nxt_idx  = exp_inc[WB_MAX-1:0] & wmask;
  assign hit      = map_r[cur_idx];
  // another delivery follows if the count allows it and the next slot is held
  assign more     = ((n_r + 1'b1) <= {1'b0, wmask}) && map_r[nxt_idx];

  assign seq_ext  = SW_W'(q_item.seq);
  assign gap      = (seq_ext - exp_r) & seq_mask;
  assign in_win   = ~|(gap & ~win_lo);
  assign in_idx   = q_item.seq[WB_MAX-1:0] & wmask;

  always_comb begin
    state_nxt     = state_r;
    exp_nxt       = exp_r;
    map_nxt       = map_r;
    drop_nxt      = drop_r;
    dr_nxt        = dr_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;
    q_pop         = 1'b0;

    unique case (state_r)
      ST_IDLE: begin
        if (q_valid) begin
          if (q_item.invalid) begin
            if (can_emit) begin
              q_pop         = 1'b1;
              out_valid_nxt = 1'b1;
              res_nxt       = '{delivered_valid: 1'b0, delivered_seq: '0,
                                last_result: 1'b1, dropped: 1'b0,
                                invalid_packet: 1'b1, drop_total: drop_r,
                                next_expected: exp_r[SEQ_W-1:0]};
            end
          end else begin
            q_pop = 1'b1;
            if (in_win && !map_r[in_idx]) begin
              map_nxt[in_idx] = 1'b1;
              dr_nxt          = 1'b0;
            end else begin
              dr_nxt = 1'b1;
              if (drop_r != DROP_MAX) begin
                drop_nxt = drop_r + 1'b1;
              end
            end
            n_nxt     = '0;
            state_nxt = ST_DRAIN;
          end
        end
      end
      ST_DRAIN: begin
        if (can_emit) begin
          out_valid_nxt = 1'b1;
          if (hit) begin
            map_nxt[cur_idx] = 1'b0;
            exp_nxt          = exp_inc;
            n_nxt            = n_r + 1'b1;
            res_nxt          = '{delivered_valid: 1'b1,
                                 delivered_seq: exp_r[SEQ_W-1:0],
                                 last_result: !more, dropped: dr_r,
                                 invalid_packet: 1'b0, drop_total: drop_r,
                                 next_expected: exp_inc[SEQ_W-1:0]};
            if (!more) begin
              state_nxt = ST_IDLE;
            end
          end else begin
            res_nxt   = '{delivered_valid: 1'b0, delivered_seq: '0,
                          last_result: 1'b1, dropped: dr_r,
                          invalid_packet: 1'b0, drop_total: drop_r,
                          next_expected: exp_r[SEQ_W-1:0]};
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase

    // register write restarts the window
    if (reload) begin
      exp_nxt = init_exp;
      map_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      exp_r       <= '0;
      map_r       <= '0;
      drop_r      <= '0;
      n_r         <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      exp_r       <= exp_nxt;
      map_r       <= map_nxt;
      drop_r      <= drop_nxt;
      n_r         <= n_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dr_r  <= dr_nxt;
    res_r <= res_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_res   = res_r;

endmodule : swr_back
`default_nettype wire

### sim/reorder_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// reorder_checker
// watches the config port and both beat channels of the reorder receiver,
// predicts every result beat from its own copy of the window state and
// compares the beats that come out, in order, field by field
// ----------------------------------------------------------------------------
module reorder_checker import swr_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic                  in_valid,
  input  wire logic                  in_ready,
  input  wire logic [SEQ_W-1:0]      in_sequence_number,
  input  wire logic                  out_valid,
  input  wire logic                  out_ready,
  input  wire logic                  out_delivered_valid,
  input  wire logic [SEQ_W-1:0]      out_delivered_seq,
  input  wire logic                  out_last_result,
  input  wire logic                  out_dropped,
  input  wire logic                  out_invalid_packet,
  input  wire logic [CNT_W-1:0]      out_drop_total,
  input  wire logic [SEQ_W-1:0]      out_next_expected,
  output int                         fail_count,
  output int                         pending,
  output int                         view_mask,
  output int                         view_window,
  output int                         view_next
);

  localparam int SEQ_BITS_CAP = 16;
  localparam int HOLD_SLOTS   = 64;
  localparam int REPORT_MAX   = 10;

  logic [4:0]            seq_bits_r;
  logic [2:0]            win_bits_r;
  logic [SEQ_W-1:0]      init_exp_r;
  logic [SEQ_W-1:0]      next_seq;
  logic [HOLD_SLOTS-1:0] held;
  logic [CNT_W-1:0]      drop_cnt;
  swr_result_t           deliveries_due[$];
  swr_result_t           got;
  swr_result_t           want;
  int                    mismatches = 0;

  assign fail_count = mismatches;

  function automatic int mod_bits();
    int b;
    b = int'(seq_bits_r);
    if (b < 1) b = 1;
    if (b > SEQ_BITS_CAP) b = SEQ_BITS_CAP;
    return b;
  endfunction

  function automatic int mod_mask();
    return (1 << mod_bits()) - 1;
  endfunction

  // window never wider than the sequence space or the bitmap
  function automatic int window_len();
    int wb;
    wb = int'(win_bits_r);
    if (wb > mod_bits()) wb = mod_bits();
    while (wb > 0 && (1 << wb) > HOLD_SLOTS) wb--;
    return 1 << wb;
  endfunction

  function automatic void restart_window();
    next_seq = init_exp_r & SEQ_W'(mod_mask());
    held     = '0;
  endfunction

  task automatic predict_beat(input logic [SEQ_W-1:0] s);
    swr_result_t      r;
    logic [SEQ_W-1:0] mask;
    logic [SEQ_W-1:0] gap;
    logic             lost;
    int               w;
    int               n;
    int               slot;
    mask = SEQ_W'(mod_mask());
    w    = window_len();
    n    = 0;
    lost = 1'b0;
    r    = '0;
    if (s > mask) begin
      // out of sequence space: status only, state untouched
      r.last_result    = 1'b1;
      r.invalid_packet = 1'b1;
      r.drop_total     = drop_cnt;
      r.next_expected  = next_seq;
      deliveries_due.push_back(r);
    end else begin
      next_seq = next_seq & mask;
      gap      = (s - next_seq) & mask;
      slot     = int'(s) & (w - 1);
      if (gap < w && !held[slot]) begin
        held[slot] = 1'b1;
      end else begin
        lost = 1'b1;
        if (drop_cnt != DROP_MAX) drop_cnt++;
      end
      r.dropped    = lost;
      r.drop_total = drop_cnt;
      while (n < w && held[int'(next_seq) & (w - 1)]) begin
        r.delivered_valid = 1'b1;
        r.delivered_seq   = next_seq;
        held[int'(next_seq) & (w - 1)] = 1'b0;
        next_seq = (next_seq + 1'b1) & mask;
        n++;
        r.next_expected = next_seq;
        r.last_result   = !(n < w && held[int'(next_seq) & (w - 1)]);
        deliveries_due.push_back(r);
      end
      if (n == 0) begin
        r.last_result   = 1'b1;
        r.next_expected = next_seq;
        deliveries_due.push_back(r);
      end
    end
  endtask

  task automatic compare_beat();
    got.delivered_valid = out_delivered_valid;
    got.delivered_seq   = out_delivered_seq;
    got.last_result     = out_last_result;
    got.dropped         = out_dropped;
    got.invalid_packet  = out_invalid_packet;
    got.drop_total      = out_drop_total;
    got.next_expected   = out_next_expected;
    if (deliveries_due.size() == 0) begin
      mismatches++;
      if (mismatches <= REPORT_MAX)
        $display("[%0t] result beat with nothing due: dv=%0d seq=%0d last=%0d drop=%0d",
                 $time, got.delivered_valid, got.delivered_seq, got.last_result,
                 got.dropped);
    end else begin
      want = deliveries_due.pop_front();
      if (got.delivered_valid !== want.delivered_valid ||
          got.delivered_seq   !== want.delivered_seq   ||
          got.last_result     !== want.last_result     ||
          got.dropped         !== want.dropped         ||
          got.invalid_packet  !== want.invalid_packet  ||
          got.drop_total      !== want.drop_total      ||
          got.next_expected   !== want.next_expected) begin
        mismatches++;
        if (mismatches <= REPORT_MAX) begin
          $display("[%0t] result mismatch", $time);
          $display("  expected dv=%0d seq=%0d last=%0d drop=%0d inv=%0d total=%0d next=%0d",
                   want.delivered_valid, want.delivered_seq, want.last_result,
                   want.dropped, want.invalid_packet, want.drop_total, want.next_expected);
          $display("  actual   dv=%0d seq=%0d last=%0d drop=%0d inv=%0d total=%0d next=%0d",
                   got.delivered_valid, got.delivered_seq, got.last_result,
                   got.dropped, got.invalid_packet, got.drop_total, got.next_expected);
        end
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      seq_bits_r = RST_SEQ_BITS;
      win_bits_r = RST_WINDOW_BITS;
      init_exp_r = RST_INIT_EXP;
      drop_cnt   = '0;
      restart_window();
      deliveries_due.delete();
    end else begin
      if (out_valid && out_ready) compare_beat();
      // any known register restarts the window, drop count survives
      if (cfg_we) begin
        case (cfg_index)
          CFG_SEQ_BITS: begin
            seq_bits_r = cfg_data[4:0];
            restart_window();
          end
          CFG_WINDOW_BITS: begin
            win_bits_r = cfg_data[2:0];
            restart_window();
          end
          CFG_INIT_EXP: begin
            init_exp_r = cfg_data;
            restart_window();
          end
          default: ;
        endcase
      end
      if (in_valid && in_ready) predict_beat(in_sequence_number);
    end
    pending     <= deliveries_due.size();
    view_mask   <= mod_mask();
    view_window <= window_len();
    view_next   <= int'(next_seq);
  end

endmodule : reorder_checker

### sim/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// stimulus and verdict for the sliding window reorder receiver: directed
// window cases, random shuffled windows with duplicate, stale and
// out-of-range beats mixed in, random stalls on both channels; all checking
// is done by reorder_checker
// ----------------------------------------------------------------------------
module testbench;
  import swr_pkg::*;

  localparam int CYCLE_LIMIT   = 4_000_000;
  localparam int SETTLE_CYCLES = 16;
  localparam int RAND_PHASES   = 8;
  localparam int PHASE_ITEMS   = 52;

  // index with no register behind it, writes must be ignored
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  logic                  in_valid;
  logic                  in_ready;
  logic [SEQ_W-1:0]      in_sequence_number;
  logic                  out_valid;
  logic                  out_ready = 1'b1;
  logic                  out_delivered_valid;
  logic [SEQ_W-1:0]      out_delivered_seq;
  logic                  out_last_result;
  logic                  out_dropped;
  logic                  out_invalid_packet;
  logic [CNT_W-1:0]      out_drop_total;
  logic [SEQ_W-1:0]      out_next_expected;

  int   fail_count;
  int   pending;
  int   view_mask;
  int   view_window;
  int   view_next;

  // calm: sender never pauses; steady: sink never stalls (registered copy)
  bit   calm = 1'b0;
  logic steady;
  int   stall_left = 0;
  int   cycle_cnt = 0;
  int   blk_order[64];

  sliding_window_reorder_receiver u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_sequence_number  (in_sequence_number),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_delivered_valid (out_delivered_valid),
    .out_delivered_seq   (out_delivered_seq),
    .out_last_result     (out_last_result),
    .out_dropped         (out_dropped),
    .out_invalid_packet  (out_invalid_packet),
    .out_drop_total      (out_drop_total),
    .out_next_expected   (out_next_expected)
  );

  reorder_checker u_chk (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_sequence_number  (in_sequence_number),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_delivered_valid (out_delivered_valid),
    .out_delivered_seq   (out_delivered_seq),
    .out_last_result     (out_last_result),
    .out_dropped         (out_dropped),
    .out_invalid_packet  (out_invalid_packet),
    .out_drop_total      (out_drop_total),
    .out_next_expected   (out_next_expected),
    .fail_count          (fail_count),
    .pending             (pending),
    .view_mask           (view_mask),
    .view_window         (view_window),
    .view_next           (view_next)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // watchdog, a hung block must not hang the run
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // pause length: mostly short, now and then a long one
  function automatic int pick_pause();
    if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
    return $urandom_range(6, 40);
  endfunction

  // result sink: random stalls unless the phase runs steady
  always @(posedge clk) begin
    if (!rst_n || steady) begin
      out_ready  <= 1'b1;
      stall_left <= 0;
    end else if (stall_left > 0) begin
      out_ready  <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 99) < 18) begin
      out_ready  <= 1'b0;
      stall_left <= pick_pause() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // one input beat; valid stays up when the next beat follows at once
  task automatic send_seq(input int s);
    int g;
    in_valid           <= 1'b1;
    in_sequence_number <= SEQ_W'(s);
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    g = 0;
    if (!calm && $urandom_range(0, 99) < 45) g = pick_pause();
    if (g > 0) begin
      in_valid <= 1'b0;
      repeat (g) @(posedge clk);
    end
  endtask

  // drop valid, wait for every due result, then let the pipe run dry
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  // junk above the field width must be masked off by the block
  task automatic load_regs(input int sb, input int wb, input int ie);
    cfg_write(CFG_SEQ_BITS, {11'($urandom), 5'(sb)});
    cfg_write(CFG_WINDOW_BITS, {13'($urandom), 3'(wb)});
    cfg_write(CFG_INIT_EXP, 16'(ie));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic spare_write();
    cfg_write(CFG_SPARE, 16'($urandom));
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  // a beat that must never be held: duplicate of this block, stale or far
  // ahead of the window, or beyond the sequence space
  task automatic send_noise(input int base, input int k, input int i, input int mask,
                            input int w, output int counted);
    int pick;
    counted = 1;
    pick    = $urandom_range(0, 2);
    if (pick == 0 && i > 0 && mask + 1 >= 2 * w) begin
      send_seq((base + blk_order[$urandom_range(0, i - 1)]) & mask);
    end else if (pick == 1 && mask + 1 > k + w) begin
      send_seq((base + k + w + int'($urandom_range(0, mask - k - w))) & mask);
    end else if (mask < 65535) begin
      send_seq($urandom_range(mask + 1, 65535));
      counted = 0;
    end else begin
      counted = 0;
    end
  endtask

  // shuffled runs of consecutive numbers starting at the expected one, so
  // the window fills out of order and drains in bursts
  task automatic run_window_phase(input int n_items, input bit quiet);
    int mask;
    int w;
    int base;
    int k;
    int i;
    int j;
    int tmp;
    int sent;
    int extra;
    calm   = quiet;
    steady <= quiet;
    mask   = view_mask;
    w      = view_window;
    base   = view_next;
    sent   = 0;
    while (sent < n_items) begin
      k = $urandom_range(1, w);
      for (i = 0; i < k; i++) blk_order[i] = i;
      for (i = k - 1; i > 0; i--) begin
        j            = $urandom_range(0, i);
        tmp          = blk_order[i];
        blk_order[i] = blk_order[j];
        blk_order[j] = tmp;
      end
      for (i = 0; i < k; i++) begin
        if ($urandom_range(0, 99) < 15) begin
          send_noise(base, k, i, mask, w, extra);
          sent += extra;
        end
        send_seq((base + blk_order[i]) & mask);
        sent++;
      end
      base = (base + k) & mask;
    end
  endtask

  task automatic random_regs();
    int r;
    int sb;
    r = $urandom_range(0, 99);
    if (r < 60) sb = $urandom_range(2, 8);
    else if (r < 85) sb = $urandom_range(9, 16);
    else sb = $urandom_range(0, 31);
    load_regs(sb, $urandom_range(0, 7), $urandom_range(0, 65535));
  endtask

  initial begin
    int ph;
    int r;
    rst_n              <= 1'b0;
    cfg_we             <= 1'b0;
    cfg_index          <= CFG_SEQ_BITS;
    cfg_data           <= '0;
    in_valid           <= 1'b0;
    in_sequence_number <= '0;
    steady             <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset settings: 8-bit numbers, window of 4, expecting 0
    send_seq(0);        // in order, delivered at once
    send_seq(2);        // held ahead of a gap
    send_seq(3);
    send_seq(3);        // duplicate of a held packet
    send_seq(1);        // fills the gap, burst of three
    send_seq(200);      // out of window
    send_seq(65535);    // beyond sequence space
    send_seq(256);      // just beyond sequence space
    send_seq(255);      // top of space, behind the window
    settle();

    // zero width acts as one bit, window clamps to the space, start masked
    load_regs(0, 7, 65535);
    send_seq(0);
    send_seq(1);        // delivers 1 then wraps to 0
    send_seq(2);
    settle();

    // width above the cap, widest window, start at the top of the space
    load_regs(31, 6, 65535);
    send_seq(1);
    send_seq(0);
    send_seq(65535);    // drains across the wrap
    send_seq(65);       // last slot of the window
    settle();
    spare_write();      // unknown index, held slot must survive
    send_seq(66);       // one past the window
    send_seq(65);       // still held, so a duplicate
    settle();

    // window of one
    load_regs(16, 0, 32768);
    send_seq(32768);
    send_seq(32770);
    send_seq(32769);
    settle();

    // random phases, the first one wide enough for full 64-deep drains
    for (ph = 0; ph < RAND_PHASES; ph++) begin
      r = $urandom_range(0, 9);
      if (ph == 0) load_regs(12, 7, $urandom_range(0, 65535));
      else if (r < 6) random_regs();
      else if (r < 8) spare_write();
      run_window_phase(PHASE_ITEMS, $urandom_range(0, 3) == 0);
      settle();
    end

    // a short random tail after one more register load
    random_regs();
    run_window_phase(15, 1'b0);
    settle();

    if (fail_count == 0 && pending == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule : testbench
